/* rtl/core/ksh_pkg.sv */
// Shared types, keyword text and HID usage lookups for the keystroke script parser.
// No dependencies; imported by keystroke_script_to_hid_reports.
`default_nettype none

package ksh_pkg;

  localparam int NUM_KW     = 12;
  localparam int DELAY_MS_W = 24;
  localparam int KW_CHARS   = 9;

  // Keyword indexes, lowest index wins when two complete on the same byte.
  localparam int KW_REM       = 0;
  localparam int KW_DELAY     = 1;
  localparam int KW_STRING    = 2;
  localparam int KW_GUI       = 3;
  localparam int KW_ENTER     = 4;
  localparam int KW_ESC       = 5;
  localparam int KW_BACKSPACE = 6;
  localparam int KW_TAB       = 7;
  localparam int KW_CTRL      = 8;
  localparam int KW_SHIFT     = 9;
  localparam int KW_ALT       = 10;
  localparam int KW_CTRLALT   = 11;

  localparam logic [3:0] MOD_NONE  = 4'h0;
  localparam logic [3:0] MOD_CTRL  = 4'h1;
  localparam logic [3:0] MOD_SHIFT = 4'h2;
  localparam logic [3:0] MOD_ALT   = 4'h4;
  localparam logic [3:0] MOD_GUI   = 4'h8;

  localparam logic [7:0] USAGE_NONE      = 8'h00;
  localparam logic [7:0] USAGE_ENTER     = 8'h28;
  localparam logic [7:0] USAGE_ESC       = 8'h29;
  localparam logic [7:0] USAGE_BACKSPACE = 8'h2A;
  localparam logic [7:0] USAGE_TAB       = 8'h2B;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic REPORT_KEY   = 1'b0;
  localparam logic REPORT_DELAY = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [DELAY_MS_W-1:0] delay_ms;
    logic [7:0]            key;
    logic [3:0]            mods;
  } hid_report_t;

  // Keyword text, left justified, zero padded to nine characters.
  function automatic logic [8*KW_CHARS-1:0] kw_text(input int k);
    logic [8*KW_CHARS-1:0] s;
    case (k)
      KW_REM:       s = {"REM", 48'd0};
      KW_DELAY:     s = {"DELAY ", 24'd0};
      KW_STRING:    s = {"STRING ", 16'd0};
      KW_GUI:       s = {"GUI", 48'd0};
      KW_ENTER:     s = {"ENTER", 32'd0};
      KW_ESC:       s = {"ESC", 48'd0};
      KW_BACKSPACE: s = "BACKSPACE";
      KW_TAB:       s = {"TAB", 48'd0};
      KW_CTRL:      s = {"CTRL", 40'd0};
      KW_SHIFT:     s = {"SHIFT", 32'd0};
      KW_ALT:       s = {"ALT", 48'd0};
      KW_CTRLALT:   s = {"CTRL-ALT", 8'd0};
      default:      s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    logic [3:0] n;
    case (k)
      KW_REM, KW_GUI, KW_ESC, KW_TAB, KW_ALT: n = 4'd3;
      KW_CTRL:                                n = 4'd4;
      KW_ENTER, KW_SHIFT:                     n = 4'd5;
      KW_DELAY:                               n = 4'd6;
      KW_STRING:                              n = 4'd7;
      KW_CTRLALT:                             n = 4'd8;
      KW_BACKSPACE:                           n = 4'd9;
      default:                                n = 4'd0;
    endcase
    return n;
  endfunction

  // Character of keyword k at position pos; zero past the end of the keyword.
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] pos);
    logic [8*KW_CHARS-1:0] s;
    logic [7:0]            c;
    s = kw_text(k);
    c = 8'h00;
    for (int i = 0; i < KW_CHARS; i++) begin
      if (pos == 4'(i) && pos < kw_len(k)) c = s[8*(KW_CHARS-1-i) +: 8];
    end
    return c;
  endfunction

  function automatic logic [7:0] letter_usage(input logic [7:0] b);
    logic [7:0] u;
    if (b inside {["A":"Z"]}) u = 8'h04 + (b - "A");
    else if (b inside {["a":"z"]}) u = 8'h04 + (b - "a");
    else u = USAGE_NONE;
    return u;
  endfunction

  // Unshifted US layout; '!' shares the key of '1'.
  function automatic logic [7:0] char_usage(input logic [7:0] b);
    logic [7:0] u;
    if (b inside {["A":"Z"], ["a":"z"]}) u = letter_usage(b);
    else if (b inside {["1":"9"]}) u = 8'h1E + (b - "1");
    else begin
      case (b)
        "0":      u = 8'h27;
        CH_SPACE: u = 8'h2C;
        CH_TAB:   u = 8'h2B;
        "-":      u = 8'h2D;
        "=":      u = 8'h2E;
        "[":      u = 8'h2F;
        "]":      u = 8'h30;
        "\\":     u = 8'h31;
        ";":      u = 8'h33;
        "'":      u = 8'h34;
        ",":      u = 8'h36;
        ".":      u = 8'h37;
        "/":      u = 8'h38;
        "!":      u = 8'h1E;
        default:  u = USAGE_NONE;
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/keystroke_script_to_hid_reports.sv */
// Keystroke script parser: script bytes in, keyboard reports and delay requests out.
// Depends on ksh_pkg for keyword text, usage tables and the report type.
//
//   channel  | dir | tdata (low bit up)                        | tuser        | tlast
//   s_axis   | in  | script_byte[7:0]                          | -            | end_of_script
//   m_axis   | out | modifier_bits[3:0], key_usage[7:0],       | report_kind  | -
//            |     | delay_ms[23:0], 4 zero bits               |              |
//
// One script byte is taken per cycle while tready is high; its report, if any, is
// registered for m_axis. The cost per byte is one pass through the keyword compare
// and the delay multiply-add. A two-entry output (register plus skid) lets input
// beats continue while one report waits; tready drops only when both are full.
// rst is synchronous and puts the parser at line start with both output slots empty.
`default_nettype none

module keystroke_script_to_hid_reports
  import ksh_pkg::*;
#(
  parameter int DELAY_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // script_byte[7:0]
  input  wire logic        s_axis_tlast,   // end_of_script
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [39:0] m_axis_tdata,   // modifier_bits[3:0], key_usage[7:0],
                                           // delay_ms[23:0], zero pad[3:0]
  output      logic        m_axis_tuser    // report_kind
);

  localparam logic [3:0] PH_START       = 4'd0;
  localparam logic [3:0] PH_MATCH       = 4'd1;
  localparam logic [3:0] PH_IGNORE      = 4'd2;
  localparam logic [3:0] PH_DLY_WS      = 4'd3;
  localparam logic [3:0] PH_DLY_DIG     = 4'd4;
  localparam logic [3:0] PH_DLY_DONE    = 4'd5;
  localparam logic [3:0] PH_STR         = 4'd6;
  localparam logic [3:0] PH_KEY_GUI     = 4'd7;
  localparam logic [3:0] PH_KEY_CTRL    = 4'd8;
  localparam logic [3:0] PH_KEY_SHIFT   = 4'd9;
  localparam logic [3:0] PH_KEY_ALT     = 4'd10;
  localparam logic [3:0] PH_KEY_CTRLALT = 4'd11;

  localparam logic [NUM_KW-1:0] ALL_CANDS = {NUM_KW{1'b1}};
  localparam logic [DELAY_BITS-1:0] DELAY_CAP =
    (DELAY_BITS >= DELAY_MS_W) ? DELAY_BITS'({DELAY_MS_W{1'b1}}) : {DELAY_BITS{1'b1}};

  logic [3:0]            line_phase, line_phase_next;
  logic [3:0]            keyword_position, keyword_position_next;
  logic [NUM_KW-1:0]     keyword_candidates, keyword_candidates_next;
  logic [DELAY_BITS-1:0] delay_total, delay_total_next;
  logic                  delay_negative, delay_negative_next;

  hid_report_t out_rep, skid_rep, res_rep;
  logic        out_valid, skid_valid, res_valid;

  logic       s_accept;
  logic [7:0] b;
  logic       is_blank, is_digit;
  logic [7:0] letter;

  logic [NUM_KW-1:0] live, complete;
  logic              have_complete;
  logic [3:0]        first_k;

  logic [DELAY_BITS+3:0] dsum;
  logic [DELAY_BITS-1:0] dsat;

  // Result of processing the byte itself, before line end handling.
  logic [3:0]            p_phase, p_pos;
  logic [NUM_KW-1:0]     p_cands;
  logic [DELAY_BITS-1:0] p_total;
  logic                  p_neg, p_hit;
  logic [3:0]            p_mod;
  logic [7:0]            p_key;

  logic [3:0]            el_phase;
  logic [DELAY_BITS-1:0] el_total;
  logic                  el_neg, end_now;

  assign b        = s_axis_tdata;
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
  assign is_digit = b inside {["0":"9"]};
  assign letter   = letter_usage(b);

  always_comb begin
    live          = '0;
    complete      = '0;
    have_complete = 1'b0;
    first_k       = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      live[k]     = keyword_candidates[k] && (keyword_position < kw_len(k)) &&
                    (kw_char(k, keyword_position) == b);
      complete[k] = live[k] && (kw_len(k) == keyword_position + 4'd1);
    end
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (complete[k]) begin
        have_complete = 1'b1;
        first_k       = 4'(k);
      end
    end
  end

  // Running decimal value, saturated at the cap: total * 10 + digit.
  always_comb begin
    dsum = ({4'd0, delay_total} << 3) + ({4'd0, delay_total} << 1) +
           (DELAY_BITS+4)'(b[3:0]);
    dsat = (dsum > {4'd0, DELAY_CAP}) ? DELAY_CAP : dsum[DELAY_BITS-1:0];
  end

  always_comb begin
    p_phase = line_phase;
    p_pos   = keyword_position;
    p_cands = keyword_candidates;
    p_total = delay_total;
    p_neg   = delay_negative;
    p_hit   = 1'b0;
    p_mod   = MOD_NONE;
    p_key   = USAGE_NONE;
    case (line_phase)
      PH_START, PH_MATCH: begin
        if (!(line_phase == PH_START && is_blank)) begin
          p_phase = PH_MATCH;
          if (keyword_position == 4'd4 && keyword_candidates[KW_CTRL]) begin
            // "CTRL" is complete; a dash keeps only CTRL-ALT alive.
            if (b == "-" && keyword_candidates[KW_CTRLALT]) begin
              p_cands = '0;
              p_cands[KW_CTRLALT] = 1'b1;
              p_pos   = 4'd5;
            end else begin
              p_phase = PH_KEY_CTRL;
              if (!is_blank) begin
                p_phase = PH_IGNORE;
                if (letter != USAGE_NONE) begin
                  p_hit = 1'b1;
                  p_mod = MOD_CTRL;
                  p_key = letter;
                end
              end
            end
          end else begin
            p_pos   = keyword_position + 4'd1;
            p_cands = live;
            if (live == '0) begin
              p_phase = PH_IGNORE;
            end else if (have_complete) begin
              case (first_k)
                4'(KW_CTRL):    p_phase = PH_MATCH;
                4'(KW_REM):     p_phase = PH_IGNORE;
                4'(KW_DELAY):   p_phase = PH_DLY_WS;
                4'(KW_STRING):  p_phase = PH_STR;
                4'(KW_GUI):     p_phase = PH_KEY_GUI;
                4'(KW_SHIFT):   p_phase = PH_KEY_SHIFT;
                4'(KW_ALT):     p_phase = PH_KEY_ALT;
                4'(KW_CTRLALT): p_phase = PH_KEY_CTRLALT;
                4'(KW_ENTER): begin
                  p_phase = PH_IGNORE;
                  p_hit   = 1'b1;
                  p_key   = USAGE_ENTER;
                end
                4'(KW_ESC): begin
                  p_phase = PH_IGNORE;
                  p_hit   = 1'b1;
                  p_key   = USAGE_ESC;
                end
                4'(KW_BACKSPACE): begin
                  p_phase = PH_IGNORE;
                  p_hit   = 1'b1;
                  p_key   = USAGE_BACKSPACE;
                end
                default: begin
                  p_phase = PH_IGNORE;
                  p_hit   = 1'b1;
                  p_key   = USAGE_TAB;
                end
              endcase
            end
          end
        end
      end
      PH_DLY_WS: begin
        if (b inside {CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR}) begin
          p_phase = PH_DLY_WS;
        end else if (b == "+") begin
          p_phase = PH_DLY_DIG;
        end else if (b == "-") begin
          p_neg   = 1'b1;
          p_phase = PH_DLY_DIG;
        end else if (is_digit) begin
          p_total = dsat;
          p_phase = PH_DLY_DIG;
        end else begin
          p_phase = PH_DLY_DONE;
        end
      end
      PH_DLY_DIG: begin
        if (is_digit) p_total = dsat;
        else p_phase = PH_DLY_DONE;
      end
      PH_STR: begin
        p_key = char_usage(b);
        p_hit = (p_key != USAGE_NONE);
      end
      PH_KEY_GUI, PH_KEY_CTRL, PH_KEY_SHIFT, PH_KEY_ALT, PH_KEY_CTRLALT: begin
        if (!is_blank) begin
          p_phase = PH_IGNORE;
          if (letter != USAGE_NONE) begin
            p_hit = 1'b1;
            p_key = letter;
            case (line_phase)
              PH_KEY_GUI:   p_mod = MOD_GUI;
              PH_KEY_CTRL:  p_mod = MOD_CTRL;
              PH_KEY_SHIFT: p_mod = MOD_SHIFT;
              PH_KEY_ALT:   p_mod = MOD_ALT;
              default:      p_mod = MOD_CTRL | MOD_ALT;
            endcase
          end
        end
      end
      default: begin
        p_phase = line_phase;
      end
    endcase
  end

  // A newline ends the line on the state it found; the final byte of a script
  // ends it after the byte has been handled, with no delay request if it made a report.
  always_comb begin
    end_now  = (b == CH_LF) || (s_axis_tlast && !p_hit);
    el_phase = (b == CH_LF) ? line_phase : p_phase;
    el_total = (b == CH_LF) ? delay_total : p_total;
    el_neg   = (b == CH_LF) ? delay_negative : p_neg;

    line_phase_next         = p_phase;
    keyword_position_next   = p_pos;
    keyword_candidates_next = p_cands;
    delay_total_next        = p_total;
    delay_negative_next     = p_neg;

    res_rep.kind     = REPORT_KEY;
    res_rep.mods     = p_mod;
    res_rep.key      = p_key;
    res_rep.delay_ms = '0;
    res_valid        = s_accept && p_hit && (b != CH_LF);

    if (end_now || (s_axis_tlast && p_hit)) begin
      line_phase_next         = PH_START;
      keyword_position_next   = '0;
      keyword_candidates_next = ALL_CANDS;
      delay_total_next        = '0;
      delay_negative_next     = 1'b0;
    end
    if (end_now) begin
      res_valid        = s_accept &&
                         (el_phase inside {PH_DLY_WS, PH_DLY_DIG, PH_DLY_DONE}) &&
                         !el_neg && (el_total != '0);
      res_rep.kind     = REPORT_DELAY;
      res_rep.mods     = MOD_NONE;
      res_rep.key      = USAGE_NONE;
      res_rep.delay_ms = DELAY_MS_W'(el_total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase         <= PH_START;
      keyword_position   <= '0;
      keyword_candidates <= ALL_CANDS;
      delay_total        <= '0;
      delay_negative     <= 1'b0;
    end else if (s_accept) begin
      line_phase         <= line_phase_next;
      keyword_position   <= keyword_position_next;
      keyword_candidates <= keyword_candidates_next;
      delay_total        <= delay_total_next;
      delay_negative     <= delay_negative_next;
    end
  end

  // Input is only taken while the skid slot is free, so a full skid never
  // competes with a new report.
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_rep <= skid_valid ? skid_rep : res_rep;
    end else if (res_valid) begin
      skid_rep <= res_rep;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_rep.delay_ms, out_rep.key, out_rep.mods};
  assign m_axis_tuser  = out_rep.kind;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a beat while the output slot is empty");

  a_delay_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[11:0] == 12'd0))
    else $error("delay request carries key or modifier bits");

  a_key_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:12] == 28'd0))
    else $error("keyboard report carries a delay value");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_axis_tlast) |=>
      (line_phase == PH_START && keyword_position == 4'd0 &&
       keyword_candidates == ALL_CANDS && delay_total == '0))
    else $error("parser not back at line start after the final script byte");

  a_delay_capped: assert property (@(posedge clk) disable iff (rst)
    delay_total <= DELAY_CAP)
    else $error("delay accumulator above its saturation value");

endmodule

`default_nettype wire

/* tb/sv/keystroke_script_to_hid_reports_tb.sv */
// Testbench for keystroke_script_to_hid_reports: streams keystroke scripts in and checks
// every keyboard report and delay request against a line parser kept in a scoreboard.
// Depends on ksh_pkg for the report type, keyword indexes and usage constants.

module keystroke_script_to_hid_reports_tb;
  import ksh_pkg::*;

  localparam int DELAY_BITS = 24;
  localparam longint unsigned DELAY_CAP =
    (((64'd1 << DELAY_BITS) - 1) > 64'hFFFFFF) ? 64'hFFFFFF : ((64'd1 << DELAY_BITS) - 1);

  typedef enum logic [3:0] {
    PH_START, PH_MATCH, PH_IGNORE, PH_DLY_WS, PH_DLY_DIG, PH_DLY_DONE, PH_STR,
    PH_KEY_GUI, PH_KEY_CTRL, PH_KEY_SHIFT, PH_KEY_ALT, PH_KEY_CTRLALT
  } line_phase_t;

  class hid_report_scoreboard;
    string             command_words[NUM_KW];
    line_phase_t       phase;
    int unsigned       kpos;
    logic [NUM_KW-1:0] cands;
    logic [DELAY_MS_W-1:0] delay_total;
    bit                delay_negative;
    hid_report_t       pending_reports[$];
    int                errors;

    function new();
      command_words = '{"REM", "DELAY ", "STRING ", "GUI", "ENTER", "ESC", "BACKSPACE",
                        "TAB", "CTRL", "SHIFT", "ALT", "CTRL-ALT"};
      errors = 0;
      restart_line();
    endfunction

    function void restart_line();
      phase = PH_START;
      kpos = 0;
      cands = '1;
      delay_total = '0;
      delay_negative = 1'b0;
    endfunction

    function hid_report_t key_report(logic [3:0] mods, logic [7:0] key);
      hid_report_t r;
      r = '0;
      r.kind = REPORT_KEY;
      r.mods = mods;
      r.key = key;
      return r;
    endfunction

    function logic [7:0] letter_code(logic [7:0] b);
      if (b >= "A" && b <= "Z") return 8'h04 + (b - "A");
      if (b >= "a" && b <= "z") return 8'h04 + (b - "a");
      return USAGE_NONE;
    endfunction

    function logic [7:0] char_code(logic [7:0] b);
      if (letter_code(b) != USAGE_NONE) return letter_code(b);
      if (b >= "1" && b <= "9") return 8'h1E + (b - "1");
      case (b)
        "0":      return 8'h27;
        CH_SPACE: return 8'h2C;
        CH_TAB:   return 8'h2B;
        "-":      return 8'h2D;
        "=":      return 8'h2E;
        "[":      return 8'h2F;
        "]":      return 8'h30;
        "\\":     return 8'h31;
        ";":      return 8'h33;
        "'":      return 8'h34;
        ",":      return 8'h36;
        ".":      return 8'h37;
        "/":      return 8'h38;
        "!":      return 8'h1E;
        default:  return USAGE_NONE;
      endcase
    endfunction

    function bit key_after_modifier(logic [7:0] b, logic [3:0] mods, output hid_report_t r);
      logic [7:0] u;
      if (b == CH_SPACE || b == CH_TAB) return 1'b0;
      phase = PH_IGNORE;
      u = letter_code(b);
      if (u == USAGE_NONE) return 1'b0;
      r = key_report(mods, u);
      return 1'b1;
    endfunction

    function logic [3:0] modifier_of(line_phase_t ph);
      case (ph)
        PH_KEY_GUI:   return MOD_GUI;
        PH_KEY_CTRL:  return MOD_CTRL;
        PH_KEY_SHIFT: return MOD_SHIFT;
        PH_KEY_ALT:   return MOD_ALT;
        default:      return MOD_CTRL | MOD_ALT;
      endcase
    endfunction

    function void add_delay_digit(logic [7:0] b);
      longint unsigned v;
      v = longint'(delay_total) * 10 + longint'(b - "0");
      delay_total = (v > DELAY_CAP) ? DELAY_MS_W'(DELAY_CAP) : DELAY_MS_W'(v);
    endfunction

    function bit match_keyword(logic [7:0] b, output hid_report_t r);
      logic [NUM_KW-1:0] live;
      live = '0;
      // Once CTRL is complete, a dash keeps CTRL-ALT alive; anything else is the key.
      if (kpos == 4 && cands[KW_CTRL]) begin
        if (b == "-" && cands[KW_CTRLALT]) begin
          cands = '0;
          cands[KW_CTRLALT] = 1'b1;
          kpos = 5;
          return 1'b0;
        end
        phase = PH_KEY_CTRL;
        return key_after_modifier(b, MOD_CTRL, r);
      end
      for (int k = 0; k < NUM_KW; k++) begin
        if (cands[k] && kpos < command_words[k].len() && 8'(command_words[k][kpos]) == b)
          live[k] = 1'b1;
      end
      kpos++;
      cands = live;
      if (live == '0) begin
        phase = PH_IGNORE;
        return 1'b0;
      end
      for (int k = 0; k < NUM_KW; k++) begin
        if (live[k] && command_words[k].len() == kpos) begin
          case (k)
            KW_CTRL: return 1'b0;
            KW_REM: begin
              phase = PH_IGNORE;
              return 1'b0;
            end
            KW_DELAY: begin
              phase = PH_DLY_WS;
              return 1'b0;
            end
            KW_STRING: begin
              phase = PH_STR;
              return 1'b0;
            end
            KW_GUI: begin
              phase = PH_KEY_GUI;
              return 1'b0;
            end
            KW_SHIFT: begin
              phase = PH_KEY_SHIFT;
              return 1'b0;
            end
            KW_ALT: begin
              phase = PH_KEY_ALT;
              return 1'b0;
            end
            KW_CTRLALT: begin
              phase = PH_KEY_CTRLALT;
              return 1'b0;
            end
            KW_ENTER: begin
              phase = PH_IGNORE;
              r = key_report(MOD_NONE, USAGE_ENTER);
              return 1'b1;
            end
            KW_ESC: begin
              phase = PH_IGNORE;
              r = key_report(MOD_NONE, USAGE_ESC);
              return 1'b1;
            end
            KW_BACKSPACE: begin
              phase = PH_IGNORE;
              r = key_report(MOD_NONE, USAGE_BACKSPACE);
              return 1'b1;
            end
            default: begin
              phase = PH_IGNORE;
              r = key_report(MOD_NONE, USAGE_TAB);
              return 1'b1;
            end
          endcase
        end
      end
      return 1'b0;
    endfunction

    function bit parse_byte(logic [7:0] b, output hid_report_t r);
      logic [7:0] u;
      case (phase)
        PH_START: begin
          if (b == CH_SPACE || b == CH_TAB) return 1'b0;
          phase = PH_MATCH;
          return match_keyword(b, r);
        end
        PH_MATCH: return match_keyword(b, r);
        PH_DLY_WS: begin
          if (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR)
            return 1'b0;
          if (b == "+") begin
            phase = PH_DLY_DIG;
          end else if (b == "-") begin
            delay_negative = 1'b1;
            phase = PH_DLY_DIG;
          end else if (b >= "0" && b <= "9") begin
            add_delay_digit(b);
            phase = PH_DLY_DIG;
          end else begin
            phase = PH_DLY_DONE;
          end
          return 1'b0;
        end
        PH_DLY_DIG: begin
          if (b >= "0" && b <= "9") add_delay_digit(b);
          else phase = PH_DLY_DONE;
          return 1'b0;
        end
        PH_STR: begin
          u = char_code(b);
          if (u == USAGE_NONE) return 1'b0;
          r = key_report(MOD_NONE, u);
          return 1'b1;
        end
        PH_KEY_GUI, PH_KEY_CTRL, PH_KEY_SHIFT, PH_KEY_ALT, PH_KEY_CTRLALT:
          return key_after_modifier(b, modifier_of(phase), r);
        default: return 1'b0;
      endcase
    endfunction

    function bit close_line(output hid_report_t r);
      bit made;
      made = 1'b0;
      if ((phase == PH_DLY_WS || phase == PH_DLY_DIG || phase == PH_DLY_DONE) &&
          !delay_negative && delay_total != '0) begin
        r = '0;
        r.kind = REPORT_DELAY;
        r.delay_ms = delay_total;
        made = 1'b1;
      end
      restart_line();
      return made;
    endfunction

    function void note_script_byte(logic [7:0] b, bit last);
      hid_report_t r;
      bit made;
      if (b == CH_LF) begin
        made = close_line(r);
      end else begin
        made = parse_byte(b, r);
        if (last) begin
          if (made) restart_line();
          else made = close_line(r);
        end
      end
      if (made) pending_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic [39:0] data, logic user);
      hid_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none actual kind %0h tdata %h",
                 $time, user, data);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("report_kind", 32'(want.kind), 32'(user));
      compare_field("modifier_bits", 32'(want.mods), 32'(data[3:0]));
      compare_field("key_usage", 32'(want.key), 32'(data[11:4]));
      compare_field("delay_ms", 32'(want.delay_ms), 32'(data[35:12]));
      compare_field("tdata pad", 32'd0, 32'(data[39:36]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic [9:0]  stall_tick = '0;

  hid_report_scoreboard sb = new();

  logic [7:0] script_bytes[$];
  bit         script_ends[$];
  string      modifier_words[5] = '{"GUI", "CTRL", "SHIFT", "ALT", "CTRL-ALT"};
  string      single_key_words[4] = '{"ENTER", "ESC", "BACKSPACE", "TAB"};
  logic [7:0] delay_blanks[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

  keystroke_script_to_hid_reports #(.DELAY_BITS(DELAY_BITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  task automatic push_byte(logic [7:0] b);
    script_bytes.push_back(b);
    script_ends.push_back(1'b0);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(8'(s[i]));
  endtask

  task automatic mark_end_of_script();
    script_ends[script_ends.size() - 1] = 1'b1;
  endtask

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] letter_char();
    logic [7:0] ofs;
    ofs = 8'($urandom_range(0, 25));
    return ($urandom_range(0, 1) != 0) ? 8'("A") + ofs : 8'("a") + ofs;
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic push_junk(int max_len);
    repeat ($urandom_range(0, max_len)) push_byte(printable_char());
  endtask

  // One script line: mostly well-formed commands with random content, some noise and
  // truncated or mangled keywords. Most lines end in a newline, some in end_of_script.
  task automatic add_line();
    int    pick;
    int    n;
    int    start;
    string word;
    start = script_bytes.size();
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) push_byte(blank_char());
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      push_text("DELAY ");
      repeat ($urandom_range(0, 2)) push_byte(delay_blanks[$urandom_range(0, 4)]);
      n = $urandom_range(0, 9);
      if (n == 0) push_byte("+");
      if (n == 1) push_byte("-");
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
      repeat (n) push_byte(8'("0") + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) push_junk(4);
    end else if (pick < 35) begin
      push_text("STRING ");
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 5) == 0) push_byte(8'($urandom_range(1, 255)));
        else push_byte(printable_char());
      end
    end else if (pick < 55) begin
      push_text(modifier_words[$urandom_range(0, 4)]);
      repeat ($urandom_range(0, 2)) push_byte(blank_char());
      push_byte(($urandom_range(0, 4) != 0) ? letter_char() : printable_char());
      if ($urandom_range(0, 1) != 0) push_junk(3);
    end else if (pick < 70) begin
      push_text(single_key_words[$urandom_range(0, 3)]);
      if ($urandom_range(0, 2) == 0) push_junk(4);
    end else if (pick < 75) begin
      push_text("REM");
      push_junk(8);
    end else if (pick < 80) begin
      // Empty or blank line.
    end else if (pick < 90) begin
      word = sb.command_words[$urandom_range(0, NUM_KW - 1)];
      n = $urandom_range(1, word.len());
      for (int i = 0; i < n - 1; i++) push_byte(8'(word[i]));
      push_byte(printable_char());
      push_junk(3);
    end else begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(1, 255)));
    end
    if (script_bytes.size() > start && $urandom_range(0, 9) == 0) begin
      mark_end_of_script();
    end else begin
      push_byte(CH_LF);
      if ($urandom_range(0, 19) == 0) mark_end_of_script();
    end
  endtask

  task automatic send_script();
    int i;
    int burst;
    int gap;
    i = 0;
    while (i < script_bytes.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      while (burst > 0 && i < script_bytes.size()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= script_bytes[i];
        s_axis_tlast  <= script_ends[i];
        do @(posedge clk); while (!s_axis_tready);
        sb.note_script_byte(script_bytes[i], script_ends[i]);
        i++;
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Results are checked on the beat; tready follows a slowly rotating stall pattern.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata, m_axis_tuser);
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= (stall_tick[3:0] < 4'd5);
      default: m_axis_tready <= ($urandom_range(0, 1) != 0);
    endcase
  end

  initial begin
    int waited;
    // Directed lines: CTRL-ALT priority with end_of_script, blank skip, delay saturation,
    // extreme byte values, and CTRL followed by a dash that never completes CTRL-ALT.
    push_text("CTRL-ALTq");
    mark_end_of_script();
    push_text("\tESC\n");
    push_text("DELAY 99999999");
    mark_end_of_script();
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(CH_LF);
    push_text("CTRL-x\n");
    while (script_bytes.size() < 530) add_line();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_script();

    waited = 0;
    while (sb.pending_reports.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, sb.pending_reports.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
